[rtl/core/assert_macros.svh]
// assertion macros used by rrts_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication, disabled while rst_n is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/core/rrts_pkg.sv]
// package for the round robin task scheduler
// holds types, codes and constants used by the scheduler and its checkers
package rrts_pkg;
    localparam int MAX_TASKS_DEF = 16;
    localparam logic [7:0] QUANTUM_RESET = 8'd20;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_CREATE = 3'd1,
        ACT_YIELD  = 3'd2,
        ACT_SLEEP  = 3'd3,
        ACT_JOIN   = 3'd4,
        ACT_EXIT   = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_FREE   = 2'd0,
        ST_READY  = 2'd1,
        ST_SUSP   = 2'd2,
        ST_EXITED = 2'd3
    } t_task_state;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NO_SLOT = 2'd1,
        STS_BAD_TGT = 2'd2,
        STS_DONE    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_ACT,
        S_SCAN_RD,
        S_SCAN_WR,
        S_PUSH,
        S_DONE,
        S_OUT
    } t_fsm;
endpackage

[rtl/core/round_robin_task_scheduler.sv]
// top level of the round robin task scheduler
// depends on rrts_pkg; task table and ready queue live in internal memories
//
// channel   direction  contents
// s_axis    in         action, duration, target_task, exit_code
// m_axis    out        running_task, switched, new_task, status, join_value, woken_count
// cfg       in         quantum_ticks
//
// after acceptance an event sweeps the task table through a memory with
// separate read and write ports, a read state and a write-back state per
// entry, before the result becomes valid
// after reset a clearing pass writes every table entry
// the result sits in an output register; the next event is accepted at the
// earliest on the edge after the result is taken
module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], duration[18:3], target_task[22:19], exit_code[54:23]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // running_task[3:0], switched[4], new_task[8:5], status[10:9],
    // join_value[42:11], woken_count[47:43]
    output logic [47:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef struct packed {
        t_task_state st;
        logic [7:0]  q;
        logic [15:0] sl;
        logic        jv;
        logic [IW-1:0] jt;
        logic [31:0] ev;
    } t_entry;

    t_entry            r_tab [MAX_TASKS];
    logic [IW-1:0]     r_fifo [MAX_TASKS];

    t_fsm r_fsm, n_fsm;
    logic [7:0]    r_quantum;
    logic [IW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [3:0]    r_cur_old;
    logic          r_busy_old;
    logic [IW-1:0] r_cur;
    logic [2:0]    r_act;
    logic [15:0]   r_dur;
    logic [3:0]    r_tgt;
    logic [31:0]   r_code;
    logic [CW-1:0] r_idx;
    logic          r_phase2;
    logic [1:0]    r_status;
    logic [3:0]    r_newt;
    logic [31:0]   r_jv;
    logic [4:0]    r_woken;
    logic          r_sleepers;
    logic          r_found;
    logic [IW-1:0] r_free;
    logic          r_tgt_ok;
    t_entry        r_rd;
    logic [IW-1:0] r_fifo_rd;
    logic          r_ovalid;
    logic [47:0]   r_odata;

    t_entry        tab_wdata;
    logic          tab_we;
    logic [IW-1:0] tab_waddr;
    logic [IW-1:0] tab_raddr;
    logic          fifo_we;
    logic [IW-1:0] fifo_waddr;
    logic [IW-1:0] fifo_wdata;
    logic [CW:0]   tail_sum;
    logic [IW-1:0] tail;
    logic [IW-1:0] head_inc;
    logic [IW-1:0] idx;
    logic          busy;
    logic [3:0]    run_id;
    logic          sw;

    assign idx      = r_idx[IW-1:0];
    assign busy     = r_count != '0;
    assign tail_sum = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign tail     = (tail_sum >= (CW+1)'(MAX_TASKS)) ? IW'(tail_sum - (CW+1)'(MAX_TASKS))
                                                       : IW'(tail_sum);
    assign head_inc = (r_head == IW'(MAX_TASKS - 1)) ? '0 : r_head + 1'b1;
    assign run_id   = busy ? 4'(r_fifo_rd) : 4'd0;
    assign sw       = (r_busy_old != busy) || (busy && run_id != r_cur_old);

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab[tab_waddr] <= tab_wdata;
        end
        r_rd <= r_tab[tab_raddr];
        if (fifo_we) begin
            r_fifo[fifo_waddr] <= fifo_wdata;
        end
        r_fifo_rd <= r_fifo[r_head];
    end

    assign s_axis_tready = (r_fsm == S_IDLE) && !r_ovalid;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            S_CLEAR:   if (idx == IW'(MAX_TASKS - 1)) n_fsm = S_IDLE;
            S_IDLE:    if (s_axis_tvalid && s_axis_tready) n_fsm = S_HEAD;
            S_HEAD:    n_fsm = S_ACT;
            S_ACT:     n_fsm = S_SCAN_RD;
            S_SCAN_RD: n_fsm = S_SCAN_WR;
            S_SCAN_WR: n_fsm = (r_idx == CW'(MAX_TASKS)) ? S_PUSH : S_SCAN_RD;
            S_PUSH:    n_fsm = S_DONE;
            S_DONE:    n_fsm = S_OUT;
            S_OUT:     n_fsm = S_IDLE;
            default:   n_fsm = S_IDLE;
        endcase
    end

    // head entry modification, written back in S_ACT before the scan
    t_entry head_mod;
    logic   head_we;
    always_comb begin
        head_mod = r_rd;
        head_we  = 1'b0;
        if (r_busy_old) begin
            unique case (r_act)
                ACT_TICK: begin
                    head_we = 1'b1;
                    head_mod.q = (r_rd.q == '0) ? r_quantum : r_rd.q - 8'd1;
                end
                ACT_SLEEP: if (r_dur != '0) begin
                    head_we = 1'b1;
                    head_mod.sl = r_dur;
                    head_mod.jv = 1'b0;
                    head_mod.jt = '0;
                    head_mod.st = ST_SUSP;
                end
                ACT_JOIN: if (r_tgt_ok) begin
                    head_we = 1'b1;
                    head_mod.jv = 1'b1;
                    head_mod.jt = IW'(r_tgt);
                    head_mod.sl = '0;
                    head_mod.st = ST_SUSP;
                end
                ACT_EXIT: begin
                    head_we = 1'b1;
                    head_mod.ev = r_code;
                    head_mod.st = ST_EXITED;
                end
                default: ;
            endcase
        end
    end

    logic head_rot;
    always_comb begin
        head_rot = 1'b0;
        if (r_busy_old) begin
            unique case (r_act)
                ACT_TICK:  head_rot = r_rd.q == '0;
                ACT_YIELD: head_rot = 1'b1;
                ACT_SLEEP: head_rot = r_dur == '0;
                default:   head_rot = 1'b0;
            endcase
        end
    end
    logic head_pop;
    assign head_pop = r_busy_old && ((r_act == ACT_SLEEP && r_dur != '0)
                      || (r_act == ACT_JOIN && r_tgt_ok) || r_act == ACT_EXIT);

    // memory port controls and scan decisions
    logic do_wake;
    always_comb begin
        tab_we     = 1'b0;
        tab_waddr  = idx;
        tab_wdata  = r_rd;
        tab_raddr  = idx;
        fifo_we    = 1'b0;
        fifo_waddr = tail;
        fifo_wdata = idx;
        do_wake    = 1'b0;
        unique case (r_fsm)
            S_CLEAR: begin
                tab_we = 1'b1;
                tab_wdata = '{st: (idx == '0) ? ST_READY : ST_FREE, q: QUANTUM_RESET,
                              sl: '0, jv: 1'b0, jt: '0, ev: '0};
                fifo_we = 1'b1;
                fifo_waddr = idx;
                fifo_wdata = '0;
            end
            S_HEAD: tab_raddr = r_fifo_rd;
            S_ACT: begin
                // head entry write-back and rotate to the tail
                tab_we = head_we;
                tab_waddr = r_cur;
                tab_wdata = head_mod;
                fifo_we = head_rot;
                fifo_wdata = r_cur;
            end
            S_SCAN_WR: begin
                tab_waddr = IW'(r_idx - 1'b1);
                fifo_wdata = tab_waddr;
                if (!r_phase2) begin
                    // sweep over all entries: sleep countdown on a tick, join wake-up on an exit
                    if (r_act == ACT_TICK && r_rd.st == ST_SUSP && r_rd.sl != '0) begin
                        tab_we = 1'b1;
                        tab_wdata.sl = r_rd.sl - 16'd1;
                        if (r_rd.sl == 16'd1) begin
                            do_wake = 1'b1;
                            tab_wdata.st = ST_READY;
                        end
                    end
                    if (r_act == ACT_EXIT && r_busy_old && r_rd.st == ST_SUSP && r_rd.jv
                        && r_rd.jt == r_cur) begin
                        do_wake = 1'b1;
                        tab_we = 1'b1;
                        tab_wdata.jv = 1'b0;
                        tab_wdata.jt = '0;
                        tab_wdata.st = ST_READY;
                    end
                    fifo_we = do_wake && (r_count < CW'(MAX_TASKS));
                end
            end
            S_PUSH: begin
                // commit a create event's write to the new entry and queue it
                tab_waddr = r_found ? r_free : r_cur;
                if (r_act == ACT_CREATE && r_found) begin
                    tab_we = 1'b1;
                    tab_wdata = '{st: ST_READY, q: r_quantum, sl: '0, jv: 1'b0,
                                  jt: '0, ev: '0};
                    fifo_we = r_count < CW'(MAX_TASKS);
                    fifo_wdata = r_free;
                end
            end
            default: ;
        endcase
    end

    // task state copy in flip-flops for the join target check
    t_task_state r_st_sh [MAX_TASKS];
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_st_sh[tab_waddr] <= tab_wdata.st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= S_CLEAR;
            r_idx     <= '0;
            r_quantum <= QUANTUM_RESET;
            r_head    <= '0;
            r_count   <= CW'(1);
            r_ovalid  <= 1'b0;
            r_cur_old <= '0;
        end else begin
            r_fsm <= n_fsm;
            if (i_cfg_valid && o_cfg_ready) begin
                r_quantum <= i_cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_fsm)
                S_CLEAR: r_idx <= r_idx + 1'b1;
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_act  <= s_axis_tdata[2:0];
                    r_dur  <= s_axis_tdata[18:3];
                    r_tgt  <= s_axis_tdata[22:19];
                    r_code <= s_axis_tdata[54:23];
                    r_busy_old <= busy;
                    r_idx  <= '0;
                    r_status <= STS_OK;
                    r_newt <= '0;
                    r_jv   <= '0;
                    r_woken <= '0;
                    r_sleepers <= 1'b0;
                    r_found <= 1'b0;
                    r_tgt_ok <= 1'b0;
                    r_phase2 <= 1'b0;
                end
                S_HEAD: begin
                    r_cur <= busy ? r_fifo_rd : '0;
                    r_tgt_ok <= (32'(r_tgt) < MAX_TASKS) && IW'(r_tgt) != r_fifo_rd
                        && r_st_sh[IW'(r_tgt)] != ST_FREE
                        && r_st_sh[IW'(r_tgt)] != ST_EXITED;
                end
                S_ACT: begin
                    if (head_rot || head_pop) begin
                        r_head <= head_inc;
                    end
                    if (head_pop) begin
                        r_count <= r_count - 1'b1;
                    end
                    if (r_act == ACT_EXIT && r_busy_old) r_jv <= r_code;
                    if (r_act == ACT_JOIN && r_busy_old && !r_tgt_ok) begin
                        r_status <= STS_BAD_TGT;
                        r_jv <= 32'hFFFF_FFFF;
                    end
                    r_idx <= '0;
                end
                S_SCAN_RD: r_idx <= r_idx + 1'b1;
                S_SCAN_WR: begin
                    if (fifo_we) r_count <= r_count + 1'b1;
                    if (do_wake && r_woken != 5'd31) r_woken <= r_woken + 1'b1;
                    if (tab_wdata.st == ST_SUSP && tab_wdata.sl != '0) r_sleepers <= 1'b1;
                    if (!r_found && r_rd.st == ST_FREE) begin
                        r_found <= 1'b1;
                        r_free  <= tab_waddr;
                    end
                end
                S_PUSH: begin
                    if (r_act == ACT_CREATE) begin
                        if (r_found) begin
                            r_newt <= 4'(r_free);
                            if (fifo_we) r_count <= r_count + 1'b1;
                        end else begin
                            r_status <= STS_NO_SLOT;
                        end
                    end
                end
                S_DONE: begin
                    if (r_status == STS_OK && !busy && !r_sleepers) r_status <= STS_DONE;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_odata  <= {r_woken, r_jv, r_status, r_newt, sw, run_id};
                    if (busy) r_cur_old <= run_id;
                end
                default: ;
            endcase
        end
    end
endmodule

[rtl/core/rrts_checker.sv]
// port-level checker for the round robin task scheduler
// depends on rrts_pkg and assert_macros.svh; bound to the top level
`include "assert_macros.svh"
module rrts_checker
    import rrts_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output changed while stalled")
    `ASSERT_IMPL(a_excl, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "accepted with pending result")
    `ASSERT_IMPL(a_bad, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[10:9] == STS_BAD_TGT, m_axis_tdata[42:11] == 32'hFFFF_FFFF && !m_axis_tdata[4], "bad join fields")
    `ASSERT_NEXT(a_acc, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second accept")
endmodule

bind round_robin_task_scheduler rrts_checker u_chk (.*);

[tb/rrts_schedule_checker.sv]
// checker for the round robin task scheduler: watches the event, result and
// quantum channels, predicts every result and compares it field by field
// depends on rrts_pkg
module rrts_schedule_checker
    import rrts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_ev_valid,
    input  logic        i_ev_ready,
    input  logic [55:0] i_ev_data,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [47:0] i_res_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTASK = MAX_TASKS_DEF;
    localparam logic [4:0] JOIN_VALID = 5'h10;

    typedef struct packed {
        logic [4:0]  woken;
        logic [31:0] join_val;
        logic [1:0]  status;
        logic [3:0]  new_id;
        logic        switched;
        logic [3:0]  running;
    } t_sched_result;

    t_sched_result expected_results[$];

    logic [7:0]  quantum;
    logic [3:0]  ready_q[NTASK];
    int          rq_head;
    int          rq_count;
    logic [3:0]  cur_task;
    t_task_state tstate[NTASK];
    logic [7:0]  qleft[NTASK];
    logic [15:0] sleft[NTASK];
    logic [4:0]  jwait[NTASK];
    logic [31:0] xval[NTASK];

    task automatic rq_push(input int id);
        if (rq_count < NTASK) begin
            ready_q[(rq_head + rq_count) % NTASK] = id[3:0];
            rq_count++;
        end
    endtask

    task automatic rq_pop();
        if (rq_count > 0) begin
            rq_head = (rq_head + 1) % NTASK;
            rq_count--;
        end
    endtask

    task automatic rq_rotate();
        logic [3:0] id;
        if (rq_count > 0) begin
            id = ready_q[rq_head];
            rq_pop();
            rq_push(id);
        end
    endtask

    task automatic reset_state();
        quantum = QUANTUM_RESET;
        for (int i = 0; i < NTASK; i++) begin
            ready_q[i] = '0;
            tstate[i] = ST_FREE;
            qleft[i] = QUANTUM_RESET;
            sleft[i] = '0;
            jwait[i] = '0;
            xval[i] = '0;
        end
        tstate[0] = ST_READY;
        rq_head = 0;
        rq_count = 1;
        cur_task = '0;
    endtask

    task automatic schedule_event(input logic [55:0] d, output t_sched_result r);
        logic [2:0]  act;
        logic [15:0] dur;
        logic [3:0]  tgt;
        logic [31:0] code;
        logic        was_busy;
        logic        busy;
        logic        sleepers;
        logic [3:0]  old;
        int          cur;
        int          slot;
        int          woken;
        act = d[2:0];
        dur = d[18:3];
        tgt = d[22:19];
        code = d[54:23];
        was_busy = rq_count > 0;
        old = cur_task;
        cur = was_busy ? int'(ready_q[rq_head]) : 0;
        r = '0;
        woken = 0;
        sleepers = 1'b0;
        case (act)
            ACT_TICK: begin
                if (was_busy) begin
                    if (qleft[cur] == 0) begin
                        qleft[cur] = quantum;
                        rq_rotate();
                    end else begin
                        qleft[cur]--;
                    end
                end
                for (int i = 0; i < NTASK; i++) begin
                    if (tstate[i] == ST_SUSP && sleft[i] != 0) begin
                        sleft[i]--;
                        if (sleft[i] == 0) begin
                            tstate[i] = ST_READY;
                            rq_push(i);
                            woken++;
                        end
                    end
                end
            end
            ACT_CREATE: begin
                slot = NTASK;
                for (int i = NTASK - 1; i >= 0; i--)
                    if (tstate[i] == ST_FREE) slot = i;
                if (slot == NTASK) begin
                    r.status = STS_NO_SLOT;
                end else begin
                    tstate[slot] = ST_READY;
                    qleft[slot] = quantum;
                    sleft[slot] = '0;
                    jwait[slot] = '0;
                    xval[slot] = '0;
                    rq_push(slot);
                    r.new_id = slot[3:0];
                end
            end
            ACT_YIELD: begin
                if (was_busy) rq_rotate();
            end
            ACT_SLEEP: begin
                if (was_busy) begin
                    if (dur == 0) begin
                        rq_rotate();
                    end else begin
                        sleft[cur] = dur;
                        jwait[cur] = '0;
                        tstate[cur] = ST_SUSP;
                        rq_pop();
                    end
                end
            end
            ACT_JOIN: begin
                if (was_busy) begin
                    if (int'(tgt) == cur || tstate[tgt] == ST_FREE
                            || tstate[tgt] == ST_EXITED) begin
                        r.status = STS_BAD_TGT;
                        r.join_val = '1;
                    end else begin
                        jwait[cur] = JOIN_VALID | {1'b0, tgt};
                        sleft[cur] = '0;
                        tstate[cur] = ST_SUSP;
                        rq_pop();
                    end
                end
            end
            ACT_EXIT: begin
                if (was_busy) begin
                    rq_pop();
                    xval[cur] = code;
                    tstate[cur] = ST_EXITED;
                    for (int i = 0; i < NTASK; i++) begin
                        if (tstate[i] == ST_SUSP && jwait[i][4]
                                && int'(jwait[i][3:0]) == cur) begin
                            jwait[i] = '0;
                            tstate[i] = ST_READY;
                            rq_push(i);
                            woken++;
                        end
                    end
                    r.join_val = code;
                end
            end
            default: begin
            end
        endcase
        busy = rq_count > 0;
        if (busy) cur_task = ready_q[rq_head];
        for (int i = 0; i < NTASK; i++)
            if (tstate[i] == ST_SUSP && sleft[i] != 0) sleepers = 1'b1;
        if (r.status == STS_OK && !busy && !sleepers) r.status = STS_DONE;
        if (woken > 31) woken = 31;
        r.running = busy ? cur_task : 4'd0;
        r.switched = (was_busy != busy) || (busy && cur_task != old);
        r.woken = woken[4:0];
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        reset_state();
    end

    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result exp_r;
        if (!i_rst_n) begin
            reset_state();
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = i_res_data;
                if (expected_results.size() == 0) begin
                    $error("result transaction with no event pending: %h", i_res_data);
                    o_fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("running_task", exp_r.running, got.running);
                    check_field("switched", exp_r.switched, got.switched);
                    check_field("new_task", exp_r.new_id, got.new_id);
                    check_field("status", exp_r.status, got.status);
                    check_field("join_value", exp_r.join_val, got.join_val);
                    check_field("woken_count", exp_r.woken, got.woken);
                end
            end
            if (i_cfg_valid && i_cfg_ready) quantum = i_cfg_data;
            if (i_ev_valid && i_ev_ready) begin
                schedule_event(i_ev_data, exp_r);
                expected_results.push_back(exp_r);
            end
        end
        o_pending = expected_results.size();
    end
endmodule

[tb/round_robin_task_scheduler_test.sv]
// testbench top for the round robin task scheduler: drives events and quantum
// writes with random gaps and stalls, gives the verdict
// depends on rrts_pkg, round_robin_task_scheduler and rrts_schedule_checker
module round_robin_task_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rrts_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 48;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;
    int          fail_count;
    int          pending;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    int          stall_mode = 0;

    round_robin_task_scheduler u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    rrts_schedule_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ev_valid  (s_axis_tvalid),
        .i_ev_ready  (s_axis_tready),
        .i_ev_data   (s_axis_tdata),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 120);
        end
        stall_left--;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 7) != 0);
            default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_event(input t_action act, input logic [15:0] dur,
                              input logic [3:0] tgt, input logic [31:0] code);
        s_axis_tdata <= {1'b0, code, tgt, dur, act};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 25)) @(posedge i_clk);
            end
        end
    endtask

    task automatic write_quantum(input logic [7:0] q);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_data <= q;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_events(input int n);
        int r;
        t_action act;
        logic [15:0] dur;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            dur = 16'($urandom_range(1, 6));
            if (r < 35) act = ACT_TICK;
            else if (r < 48) act = ACT_CREATE;
            else if (r < 62) act = ACT_YIELD;
            else if (r < 78) act = ACT_SLEEP;
            else if (r < 93) act = ACT_JOIN;
            else if (r < 95) act = ACT_EXIT;
            else act = t_action'(3'($urandom_range(6, 7)));
            r = $urandom_range(0, 99);
            if (r < 6) dur = '0;
            else if (r < 8) dur = 16'($urandom);
            send_event(act, dur, 4'($urandom_range(0, 15)), $urandom);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_quantum(8'd1);

        // directed events
        send_event(ACT_TICK, 16'd0, 4'd0, 32'd0);
        send_event(ACT_YIELD, 16'd0, 4'd0, 32'd0);
        send_event(ACT_CREATE, 16'd0, 4'd0, 32'd0);
        send_event(ACT_CREATE, 16'd0, 4'd0, 32'd0);
        send_event(ACT_JOIN, 16'd0, 4'd0, 32'd0);
        send_event(ACT_JOIN, 16'd0, 4'd1, 32'd0);
        send_event(ACT_JOIN, 16'd0, 4'd15, 32'd0);
        send_event(ACT_JOIN, 16'd0, 4'd2, 32'd0);
        send_event(ACT_SLEEP, 16'd0, 4'd0, 32'd0);
        send_event(ACT_SLEEP, 16'd3, 4'd0, 32'd0);
        send_event(ACT_TICK, 16'd0, 4'd0, 32'd0);
        send_event(ACT_TICK, 16'd0, 4'd0, 32'd0);
        send_event(ACT_EXIT, 16'd0, 4'd0, 32'h8000_0000);
        send_event(ACT_TICK, 16'd0, 4'd0, 32'd0);
        send_event(ACT_TICK, 16'd0, 4'd0, 32'd0);
        send_event(t_action'(3'd6), 16'hFFFF, 4'd15, 32'hFFFF_FFFF);
        send_event(t_action'(3'd7), 16'hFFFF, 4'd15, 32'hFFFF_FFFF);
        send_event(ACT_EXIT, 16'd0, 4'd0, 32'h7FFF_FFFF);
        send_event(ACT_JOIN, 16'd0, 4'd1, 32'd0);
        send_event(ACT_EXIT, 16'hFFFF, 4'd15, 32'h0000_0000);
        send_event(ACT_YIELD, 16'd0, 4'd0, 32'd0);
        send_event(ACT_SLEEP, 16'd5, 4'd0, 32'd0);
        send_event(ACT_CREATE, 16'd0, 4'd0, 32'd0);

        write_quantum(8'd255);
        random_events(350);
        write_quantum(8'd2);
        random_events(350);
        write_quantum(8'($urandom_range(1, 255)));
        random_events(350);
        write_quantum(8'd1);
        random_events(350);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
